FILE: rtl/msm_pkg.sv
// Shared constants and helpers for the multi-pattern string matcher.
// No dependencies; every other file of the block but msm_ram imports this package.
package msm_pkg;

    localparam int MAX_NODES     = 1024;
    localparam int ALPHABET      = 26;
    localparam int POSITION_BITS = 20;

    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int CNT_W      = NODE_W + 1;
    localparam int LETTER_W   = 5;
    localparam int CMD_W      = 3;
    localparam int ERR_W      = 2;
    localparam int COL_W      = $clog2(ALPHABET);
    localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;
    localparam int GOTO_AW    = $clog2(GOTO_DEPTH);

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PATTERN = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEND    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BUILD   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TEXT    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RESTART = 3'd5;

    localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LETTER = 2'd2;
    localparam logic [ERR_W-1:0] ERR_PHASE  = 2'd3;

    // Flat address of one goto entry: row of the node, column of the letter.
    function automatic logic [GOTO_AW-1:0] goto_addr(input logic [NODE_W-1:0] node,
                                                     input logic [COL_W-1:0] col);
        goto_addr = GOTO_AW'(node) * GOTO_AW'(ALPHABET) + GOTO_AW'(col);
    endfunction

endpackage

FILE: rtl/msm_if.sv
// Valid/ready channel interfaces for the matcher's input and result streams.
// Depends on msm_pkg for the field widths.
interface msm_in_if import msm_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [LETTER_W-1:0] letter;

    modport source (output valid, output cmd, output letter, input ready);
    modport sink   (input valid, input cmd, input letter, output ready);
endinterface

interface msm_out_if import msm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     match_found;
    logic [POSITION_BITS-1:0] end_position;
    logic [ERR_W-1:0]         error_code;

    modport source (output valid, output match_found, output end_position,
                    output error_code, input ready);
    modport sink   (input valid, input match_found, input end_position,
                    input error_code, output ready);
endinterface

FILE: rtl/msm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module msm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/multi_pattern_string_matcher_top.sv
// Aho-Corasick matcher: trie insert, breadth-first build and text scan over RAMs.
// A pattern letter that allocates a node also clears that node's goto row; the build
// walks the goto entries through the single goto RAM read port.
// One item at a time; the next transfer is taken once the result reaches the
// output register. After reset and after a clear the root row is swept.
module multi_pattern_string_matcher_top
    import msm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    msm_in_if.sink           in_ch,
    msm_out_if.source        out_ch
);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_ROWCLR = 16'h0002,
        S_PL_CHK = 16'h0004,
        S_B0_RD  = 16'h0008,
        S_B0_CHK = 16'h0010,
        S_B_POP  = 16'h0020,
        S_B_FAIL = 16'h0040,
        S_B_GETF = 16'h0080,
        S_B_RDV  = 16'h0100,
        S_B_RDF  = 16'h0200,
        S_B_GOTF = 16'h0400,
        S_B_FLF  = 16'h0800,
        S_B_FLV  = 16'h1000,
        S_T_FLAG = 16'h2000,
        S_T_RES  = 16'h4000,
        S_FIN    = 16'h8000
    } state_t;

    localparam logic [COL_W-1:0]         LAST_COL = COL_W'(ALPHABET - 1);
    localparam logic [CNT_W-1:0]         NODES_MAX = CNT_W'(MAX_NODES);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    state_t state_reg, state_next;
    logic [LETTER_W-1:0] letter_reg, letter_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic [NODE_W-1:0]   scan_reg, scan_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                built_reg, built_next;
    logic                reply_reg, reply_next;
    logic [NODE_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [CNT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    tail_reg, tail_next;
    logic [NODE_W-1:0]   u_reg, u_next;
    logic [NODE_W-1:0]   f_reg, f_next;
    logic [NODE_W-1:0]   v_reg, v_next;
    logic                fvflag_reg, fvflag_next;
    logic                res_match_reg, res_match_next;
    logic [POSITION_BITS-1:0] res_pos_reg, res_pos_next;
    logic [ERR_W-1:0]    res_err_reg, res_err_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_match_reg, out_match_next;
    logic [POSITION_BITS-1:0] out_pos_reg, out_pos_next;
    logic [ERR_W-1:0]    out_err_reg, out_err_next;

    logic                goto_we, fail_we, flag_we, queue_we;
    logic [GOTO_AW-1:0]  goto_waddr, goto_raddr;
    logic [NODE_W-1:0]   goto_wdata, goto_rdata;
    logic [NODE_W-1:0]   fail_waddr, fail_raddr, fail_wdata, fail_rdata;
    logic [NODE_W-1:0]   flag_waddr, flag_raddr;
    logic                flag_wdata, flag_rdata;
    logic [NODE_W-1:0]   queue_waddr, queue_raddr, queue_wdata, queue_rdata;
    logic                in_fire;
    logic                letter_ok;

    msm_ram #(.WIDTH(NODE_W), .DEPTH(GOTO_DEPTH)) u_goto (
        .clk(clk), .we(goto_we), .waddr(goto_waddr), .wdata(goto_wdata),
        .raddr(goto_raddr), .rdata(goto_rdata)
    );

    msm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
        .clk(clk), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
        .raddr(fail_raddr), .rdata(fail_rdata)
    );

    msm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_flag (
        .clk(clk), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
        .raddr(flag_raddr), .rdata(flag_rdata)
    );

    msm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
        .raddr(queue_raddr), .rdata(queue_rdata)
    );

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign in_fire             = in_ch.valid && in_ch.ready;
    assign letter_ok           = (in_ch.letter < LETTER_W'(ALPHABET));
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.match_found  = out_match_reg;
    assign out_ch.end_position = out_pos_reg;
    assign out_ch.error_code   = out_err_reg;

    always_comb
    begin
        state_next     = state_reg;
        letter_next    = letter_reg;
        cursor_next    = cursor_reg;
        scan_next      = scan_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        built_next     = built_reg;
        reply_next     = reply_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        u_next         = u_reg;
        f_next         = f_reg;
        v_next         = v_reg;
        fvflag_next    = fvflag_reg;
        res_match_next = res_match_reg;
        res_pos_next   = res_pos_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_match_next = out_match_reg;
        out_pos_next   = out_pos_reg;
        out_err_next   = out_err_reg;

        goto_we     = 1'b0;
        goto_waddr  = goto_addr(row_reg, col_reg);
        goto_wdata  = '0;
        goto_raddr  = '0;
        fail_we     = 1'b0;
        fail_waddr  = row_reg;
        fail_wdata  = '0;
        fail_raddr  = queue_rdata;
        flag_we     = 1'b0;
        flag_waddr  = row_reg;
        flag_wdata  = 1'b0;
        flag_raddr  = goto_rdata;
        queue_we    = 1'b0;
        queue_waddr = tail_reg[NODE_W-1:0];
        queue_wdata = goto_rdata;
        queue_raddr = head_reg[NODE_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                goto_raddr = goto_addr((in_ch.cmd == CMD_TEXT) ? scan_reg : cursor_reg,
                                       in_ch.letter[COL_W-1:0]);
                if (in_fire)
                begin
                    letter_next    = in_ch.letter;
                    res_match_next = 1'b0;
                    res_pos_next   = '0;
                    res_err_next   = ERR_OK;
                    state_next     = S_FIN;
                    unique case (in_ch.cmd)
                        CMD_CLEAR:
                        begin
                            count_next  = CNT_W'(1);
                            cursor_next = '0;
                            scan_next   = '0;
                            pos_next    = '0;
                            built_next  = 1'b0;
                            row_next    = '0;
                            col_next    = '0;
                            reply_next  = 1'b1;
                            state_next  = S_ROWCLR;
                        end
                        CMD_PATTERN:
                        begin
                            if (built_reg)
                                res_err_next = ERR_PHASE;
                            else if (!letter_ok)
                                res_err_next = ERR_LETTER;
                            else
                                state_next = S_PL_CHK;
                        end
                        CMD_PEND:
                        begin
                            if (built_reg)
                            begin
                                res_err_next = ERR_PHASE;
                            end
                            else
                            begin
                                flag_we     = (cursor_reg != '0);
                                flag_waddr  = cursor_reg;
                                flag_wdata  = 1'b1;
                                cursor_next = '0;
                            end
                        end
                        CMD_BUILD:
                        begin
                            if (built_reg)
                            begin
                                res_err_next = ERR_PHASE;
                            end
                            else
                            begin
                                col_next   = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                state_next = S_B0_RD;
                            end
                        end
                        CMD_TEXT:
                        begin
                            if (!built_reg)
                                res_err_next = ERR_PHASE;
                            else if (!letter_ok)
                                res_err_next = ERR_LETTER;
                            else
                                state_next = S_T_FLAG;
                        end
                        CMD_RESTART:
                        begin
                            if (!built_reg)
                            begin
                                res_err_next = ERR_PHASE;
                            end
                            else
                            begin
                                scan_next = '0;
                                pos_next  = '0;
                            end
                        end
                        default:
                        begin
                            res_err_next = ERR_PHASE;
                        end
                    endcase
                end
            end

            // Clears one goto row to root; a fresh node also gets no flag and root failure.
            S_ROWCLR:
            begin
                goto_we = 1'b1;
                fail_we = 1'b1;
                flag_we = 1'b1;
                col_next = col_reg + COL_W'(1);
                if (col_reg == LAST_COL)
                begin
                    col_next   = '0;
                    state_next = reply_reg ? S_FIN : S_IDLE;
                end
            end

            S_PL_CHK:
            begin
                if (goto_rdata != '0)
                begin
                    cursor_next = goto_rdata;
                    state_next  = S_FIN;
                end
                else if (count_reg >= NODES_MAX)
                begin
                    res_err_next = ERR_FULL;
                    state_next   = S_FIN;
                end
                else
                begin
                    goto_we     = 1'b1;
                    goto_waddr  = goto_addr(cursor_reg, letter_reg[COL_W-1:0]);
                    goto_wdata  = count_reg[NODE_W-1:0];
                    cursor_next = count_reg[NODE_W-1:0];
                    row_next    = count_reg[NODE_W-1:0];
                    count_next  = count_reg + CNT_W'(1);
                    col_next    = '0;
                    reply_next  = 1'b1;
                    state_next  = S_ROWCLR;
                end
            end

            S_B0_RD:
            begin
                goto_raddr = goto_addr('0, col_reg);
                state_next = S_B0_CHK;
            end

            S_B0_CHK:
            begin
                if (goto_rdata != '0 && tail_reg < NODES_MAX)
                begin
                    fail_we    = 1'b1;
                    fail_waddr = goto_rdata;
                    fail_wdata = '0;
                    queue_we   = 1'b1;
                    tail_next  = tail_reg + CNT_W'(1);
                end
                if (col_reg == LAST_COL)
                begin
                    col_next   = '0;
                    state_next = S_B_POP;
                end
                else
                begin
                    col_next   = col_reg + COL_W'(1);
                    state_next = S_B0_RD;
                end
            end

            S_B_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    head_next  = head_reg + CNT_W'(1);
                    state_next = S_B_FAIL;
                end
                else
                begin
                    built_next   = 1'b1;
                    cursor_next  = '0;
                    scan_next    = '0;
                    pos_next     = '0;
                    state_next   = S_FIN;
                end
            end

            S_B_FAIL:
            begin
                u_next     = queue_rdata;
                state_next = S_B_GETF;
            end

            S_B_GETF:
            begin
                f_next     = fail_rdata;
                col_next   = '0;
                state_next = S_B_RDV;
            end

            S_B_RDV:
            begin
                goto_raddr = goto_addr(u_reg, col_reg);
                state_next = S_B_RDF;
            end

            S_B_RDF:
            begin
                v_next     = goto_rdata;
                goto_raddr = goto_addr(f_reg, col_reg);
                state_next = S_B_GOTF;
            end

            // The goto RAM now shows the failure target's entry for this letter.
            S_B_GOTF:
            begin
                if (v_reg != '0)
                begin
                    fail_we     = 1'b1;
                    fail_waddr  = v_reg;
                    fail_wdata  = goto_rdata;
                    queue_we    = (tail_reg < NODES_MAX);
                    queue_wdata = v_reg;
                    if (tail_reg < NODES_MAX)
                        tail_next = tail_reg + CNT_W'(1);
                    state_next  = S_B_FLF;
                end
                else
                begin
                    goto_we    = 1'b1;
                    goto_waddr = goto_addr(u_reg, col_reg);
                    goto_wdata = goto_rdata;
                    if (col_reg == LAST_COL)
                        state_next = S_B_POP;
                    else
                    begin
                        col_next   = col_reg + COL_W'(1);
                        state_next = S_B_RDV;
                    end
                end
            end

            S_B_FLF:
            begin
                fvflag_next = flag_rdata;
                flag_raddr  = v_reg;
                state_next  = S_B_FLV;
            end

            S_B_FLV:
            begin
                flag_we    = 1'b1;
                flag_waddr = v_reg;
                flag_wdata = flag_rdata | fvflag_reg;
                if (col_reg == LAST_COL)
                    state_next = S_B_POP;
                else
                begin
                    col_next   = col_reg + COL_W'(1);
                    state_next = S_B_RDV;
                end
            end

            S_T_FLAG:
            begin
                scan_next  = goto_rdata;
                state_next = S_T_RES;
            end

            S_T_RES:
            begin
                res_match_next = flag_rdata;
                res_pos_next   = pos_reg;
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + POSITION_BITS'(1);
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_match_next = res_match_reg;
                    out_pos_next   = res_pos_reg;
                    out_err_next   = res_err_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ROWCLR;
            cursor_reg    <= '0;
            scan_reg      <= '0;
            count_reg     <= CNT_W'(1);
            pos_reg       <= '0;
            built_reg     <= 1'b0;
            reply_reg     <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            scan_reg      <= scan_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            built_reg     <= built_next;
            reply_reg     <= reply_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg    <= letter_next;
        u_reg         <= u_next;
        f_reg         <= f_next;
        v_reg         <= v_next;
        fvflag_reg    <= fvflag_next;
        res_match_reg <= res_match_next;
        res_pos_reg   <= res_pos_next;
        res_err_reg   <= res_err_next;
        out_match_reg <= out_match_next;
        out_pos_reg   <= out_pos_next;
        out_err_reg   <= out_err_next;
    end

endmodule

FILE: rtl/msm_checker.sv
// Port-level assertions for the matcher, attached to the top level by bind.
// Depends on msm_pkg for widths and error codes.
module msm_checker
    import msm_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     match_found,
    input logic [POSITION_BITS-1:0] end_position,
    input logic [ERR_W-1:0]         error_code
);

    // A held result stays offered until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && match_found |-> error_code == ERR_OK)
        else $error("match reported with an error");

    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_OK |-> !match_found && end_position == '0)
        else $error("rejected item carries match data");

endmodule

bind multi_pattern_string_matcher_top msm_checker u_msm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .match_found  (out_ch.match_found),
    .end_position (out_ch.end_position),
    .error_code   (out_ch.error_code)
);

FILE: tb/msm_tb_if.sv
// Testbench-side note: the channel interfaces come from rtl/msm_if.sv.
// This file holds the checker's expected-result record; depends on msm_pkg.
package msm_tb_pkg;
    import msm_pkg::*;

    typedef struct packed {
        logic                     match_found;
        logic [POSITION_BITS-1:0] end_position;
        logic [ERR_W-1:0]         error_code;
    } match_result_t;
endpackage

FILE: tb/testbench.sv
// Self-checking testbench of multi_pattern_string_matcher_top: pattern insert,
// automaton build and text scan predicted in place. Depends on msm_pkg, msm_tb_pkg
// and the channel interfaces of rtl/msm_if.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import msm_pkg::*;
    import msm_tb_pkg::*;

    logic clk;
    logic rst_n;

    msm_in_if  in_ch ();
    msm_out_if out_ch ();

    multi_pattern_string_matcher_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Predicted automaton state.
    logic [NODE_W-1:0]        trie_next [GOTO_DEPTH];
    logic [NODE_W-1:0]        fail_to [MAX_NODES];
    logic                     accepts [MAX_NODES];
    logic [NODE_W-1:0]        walk_queue [MAX_NODES];
    int unsigned              nodes_used;
    logic [NODE_W-1:0]        insert_at;
    logic [NODE_W-1:0]        scan_at;
    logic [POSITION_BITS-1:0] text_pos;
    logic                     automaton_built;

    match_result_t pending_results[$];
    int            fail_count;
    longint        cycle_count;
    logic          idle_enable;
    logic          hold_off;

    localparam longint CYCLE_LIMIT = 3_000_000;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned slot(int unsigned node, int unsigned col);
        return node * ALPHABET + col;
    endfunction

    function automatic void clear_trie();
        for (int c = 0; c < ALPHABET; c++)
            trie_next[c] = '0;
        accepts[0]      = 1'b0;
        fail_to[0]      = '0;
        nodes_used      = 1;
        insert_at       = '0;
        scan_at         = '0;
        text_pos        = '0;
        automaton_built = 1'b0;
    endfunction

    function automatic void build_links();
        int unsigned head;
        int unsigned tail;
        int unsigned u;
        int unsigned f;
        int unsigned v;
        int unsigned fv;
        head = 0;
        tail = 0;
        for (int c = 0; c < ALPHABET; c++)
        begin
            v = trie_next[slot(0, c)];
            if (v != 0 && tail < MAX_NODES)
            begin
                fail_to[v] = '0;
                walk_queue[tail++] = NODE_W'(v);
            end
        end
        while (head < tail)
        begin
            u = walk_queue[head++];
            f = fail_to[u];
            for (int c = 0; c < ALPHABET; c++)
            begin
                v = trie_next[slot(u, c)];
                if (v != 0)
                begin
                    fv = trie_next[slot(f, c)];
                    fail_to[v] = NODE_W'(fv);
                    accepts[v] = accepts[v] | accepts[fv];
                    if (tail < MAX_NODES)
                        walk_queue[tail++] = NODE_W'(v);
                end
                else
                    trie_next[slot(u, c)] = trie_next[slot(f, c)];
            end
        end
    endfunction

    function automatic match_result_t predict_match(logic [CMD_W-1:0] cmd,
                                                    logic [LETTER_W-1:0] letter);
        match_result_t r;
        int unsigned   n;
        r = '0;
        case (cmd)
            CMD_CLEAR: clear_trie();
            CMD_PATTERN:
                if (automaton_built) r.error_code = ERR_PHASE;
                else if (letter >= ALPHABET) r.error_code = ERR_LETTER;
                else if (trie_next[slot(insert_at, letter)] != 0)
                    insert_at = trie_next[slot(insert_at, letter)];
                else if (nodes_used >= MAX_NODES) r.error_code = ERR_FULL;
                else
                begin
                    n = nodes_used++;
                    for (int c = 0; c < ALPHABET; c++)
                        trie_next[slot(n, c)] = '0;
                    accepts[n] = 1'b0;
                    fail_to[n] = '0;
                    trie_next[slot(insert_at, letter)] = NODE_W'(n);
                    insert_at = NODE_W'(n);
                end
            CMD_PEND:
                if (automaton_built) r.error_code = ERR_PHASE;
                else
                begin
                    if (insert_at != 0) accepts[insert_at] = 1'b1;
                    insert_at = '0;
                end
            CMD_BUILD:
                if (automaton_built) r.error_code = ERR_PHASE;
                else
                begin
                    build_links();
                    automaton_built = 1'b1;
                    insert_at = '0;
                    scan_at = '0;
                    text_pos = '0;
                end
            CMD_TEXT:
                if (!automaton_built) r.error_code = ERR_PHASE;
                else if (letter >= ALPHABET) r.error_code = ERR_LETTER;
                else
                begin
                    scan_at = trie_next[slot(scan_at, letter)];
                    r.match_found = accepts[scan_at];
                    r.end_position = text_pos;
                    if (text_pos != '1) text_pos++;
                end
            CMD_RESTART:
                if (!automaton_built) r.error_code = ERR_PHASE;
                else
                begin
                    scan_at = '0;
                    text_pos = '0;
                end
            default: r.error_code = ERR_PHASE;
        endcase
        return r;
    endfunction

    // Valid stays high from one transfer to the next unless a gap or a drain drops it.
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [LETTER_W-1:0] letter);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.cmd    <= cmd;
        in_ch.letter <= letter;
        do @(posedge clk); while (!in_ch.ready);
        pending_results.insert(pending_results.size(), predict_match(cmd, letter));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_word(string w);
        for (int i = 0; i < w.len(); i++)
            send_item(CMD_PATTERN, LETTER_W'(w[i] - 8'h61));
        send_item(CMD_PEND, '0);
    endtask

    task automatic send_text(string w);
        for (int i = 0; i < w.len(); i++)
            send_item(CMD_TEXT, LETTER_W'(w[i] - 8'h61));
    endtask

    // Extremes, every command, phase errors, bad letters, empty pattern.
    task automatic test_directed();
        send_item(CMD_TEXT, 5'd0);
        send_item(CMD_RESTART, 5'd0);
        send_item(3'd6, 5'd31);
        send_item(3'd7, 5'd0);
        send_item(CMD_PATTERN, 5'd26);
        send_item(CMD_PATTERN, 5'd31);
        send_item(CMD_PEND, 5'd0);
        send_word("he");
        send_word("she");
        send_word("hers");
        send_item(CMD_PATTERN, 5'd25);
        send_item(CMD_BUILD, 5'd0);
        send_item(CMD_PATTERN, 5'd1);
        send_item(CMD_PEND, 5'd0);
        send_item(CMD_BUILD, 5'd0);
        send_text("ushers");
        send_item(CMD_TEXT, 5'd31);
        send_item(CMD_RESTART, 5'd0);
        send_item(CMD_TEXT, 5'd25);
        send_item(CMD_CLEAR, 5'd0);
    endtask

    // Fill the node table to the limit so the full condition is reported.
    task automatic test_table_full();
        int unsigned run;
        send_item(CMD_CLEAR, '0);
        while (nodes_used < MAX_NODES)
        begin
            run = $urandom_range(1, 40);
            for (int i = 0; i < run; i++)
                send_item(CMD_PATTERN, LETTER_W'($urandom_range(0, ALPHABET - 1)));
            send_item(CMD_PEND, '0);
        end
        send_item(CMD_PATTERN, LETTER_W'($urandom_range(0, ALPHABET - 1)));
        send_item(CMD_PATTERN, LETTER_W'($urandom_range(0, ALPHABET - 1)));
        send_item(CMD_BUILD, '0);
        for (int i = 0; i < 60; i++)
            send_item(CMD_TEXT, LETTER_W'($urandom_range(0, ALPHABET - 1)));
    endtask

    // Rounds of random alphabets of 2 to 26 letters; a little noise mixed in.
    task automatic test_random_rounds(int items);
        int sent;
        int span;
        int plen;
        sent = 0;
        while (sent < items)
        begin
            send_item(CMD_CLEAR, '0);
            span = $urandom_range(2, ALPHABET);
            repeat ($urandom_range(1, 8))
            begin
                plen = $urandom_range(0, 5);
                for (int i = 0; i < plen; i++)
                    send_item(CMD_PATTERN, LETTER_W'($urandom_range(0, span - 1)));
                if ($urandom_range(0, 9) == 0)
                    send_item(3'($urandom_range(0, 7)), 5'($urandom));
                send_item(CMD_PEND, '0);
                sent += plen + 1;
            end
            send_item(CMD_BUILD, '0);
            repeat ($urandom_range(10, 40))
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(3'($urandom_range(1, 7)), 5'($urandom));
                else
                    send_item(CMD_TEXT, LETTER_W'($urandom_range(0, span - 1)));
                sent++;
            end
        end
    endtask

    // Receiver holds off while items keep coming, then the sender waits for drain.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            send_text("abcabcabcab");
        join
        wait_drained();
    endtask

    // Ready side: random stall bursts, or a forced hold-off.
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_ch.ready <= 1'b0;
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 14);
                out_ch.ready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        match_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no expectation waiting");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.match_found !== want.match_found)
                begin
                    $error("match_found expected %0d got %0d", want.match_found,
                           out_ch.match_found);
                    fail_count++;
                end
                if (out_ch.end_position !== want.end_position)
                begin
                    $error("end_position expected %0d got %0d", want.end_position,
                           out_ch.end_position);
                    fail_count++;
                end
                if (out_ch.error_code !== want.error_code)
                begin
                    $error("error_code expected %0d got %0d", want.error_code,
                           out_ch.error_code);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        fail_count   = 0;
        idle_enable  = 1'b1;
        hold_off     = 1'b0;
        rst_n        = 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.cmd    <= CMD_CLEAR;
        in_ch.letter <= '0;
        clear_trie();
        repeat (9) @(posedge clk);
        rst_n = 1'b1;
        test_directed();
        wait_drained();
        test_backpressure();
        test_table_full();
        test_random_rounds(110);
        wait_drained();
        idle_enable = 1'b0;
        test_random_rounds(50);
        wait_drained();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
